FILE: rtl/mep_pkg.sv
`timescale 1ns / 1ps
package mep_pkg;

    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 32;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_REAL_ORIGIN = 2'd0,
        CFG_IMAG_TOP    = 2'd1,
        CFG_REAL_STEP   = 2'd2,
        CFG_IMAG_STEP   = 2'd3
    } t_cfg_idx;

    localparam logic signed [31:0] RST_REAL_ORIGIN = -32'sd536870912;
    localparam logic signed [31:0] RST_IMAG_TOP    = 32'sd268435456;
    localparam logic signed [31:0] RST_REAL_STEP   = 32'sd786432;
    localparam logic signed [31:0] RST_IMAG_STEP   = 32'sd524800;

    // 4.0 in the q16.48 square domain
    localparam logic signed [64:0] ESCAPE_LIMIT = 65'sd1125899906842624;
    localparam logic [31:0] COLOUR_INSIDE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [9:0] pixel_col;
        logic [9:0] pixel_row;
    } t_pix_in;

    typedef struct packed {
        logic [9:0]  out_col;
        logic [9:0]  out_row;
        logic [31:0] pixel_colour;
    } t_pix_out;

    // work handed from front to back: coordinate and c in q8.24
    typedef struct packed {
        logic [9:0]         col;
        logic [9:0]         row;
        logic signed [31:0] cr;
        logic signed [31:0] ci;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } t_fst;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SQ,
        B_UPD,
        B_FIN
    } t_bst;

    function automatic logic signed [31:0] sat_q428(input logic signed [43:0] x);
        logic signed [31:0] r;
        begin
            if (x > 44'sd2147483647) begin
                r = 32'sh7FFF_FFFF;
            end else if (x < -44'sd2147483648) begin
                r = 32'sh8000_0000;
            end else begin
                r = x[31:0];
            end
            return r;
        end
    endfunction

    // integer part toward zero of a q8.24 value
    function automatic logic signed [8:0] trunc_z(input logic signed [31:0] x);
        logic [32:0] m;
        logic [8:0]  ip;
        begin
            m  = x[31] ? (33'd0 - {x[31], x}) : {1'b0, x};
            ip = m[32:24];
            return x[31] ? $signed(9'd0 - ip) : $signed(ip);
        end
    endfunction

endpackage

FILE: rtl/mep_front.sv
`timescale 1ns / 1ps
module mep_front import mep_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_pix_in             i_pix,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_full,
    output logic                o_push,
    output t_job                o_job
);

    t_fst r_state, n_state;
    logic signed [31:0] r_real_origin, r_imag_top, r_real_step, r_imag_step;
    logic [9:0] r_col, r_row;
    logic signed [42:0] r_pr, r_pi;
    logic signed [42:0] w_pr, w_pi;
    logic signed [43:0] w_sr, w_si;
    logic signed [31:0] w_cr, w_ci;
    logic w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_origin <= RST_REAL_ORIGIN;
            r_imag_top    <= RST_IMAG_TOP;
            r_real_step   <= RST_REAL_STEP;
            r_imag_step   <= RST_IMAG_STEP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_REAL_ORIGIN: r_real_origin <= $signed(i_cfg_data);
                CFG_IMAG_TOP:    r_imag_top    <= $signed(i_cfg_data);
                CFG_REAL_STEP:   r_real_step   <= $signed(i_cfg_data);
                CFG_IMAG_STEP:   r_imag_step   <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign w_pr = $signed({1'b0, r_col}) * r_real_step;
    assign w_pi = $signed({1'b0, r_row}) * r_imag_step;
    assign w_sr = {{12{r_real_origin[31]}}, r_real_origin} + {r_pr[42], r_pr};
    assign w_si = {{12{r_imag_top[31]}}, r_imag_top} - {r_pi[42], r_pi};
    assign w_cr = sat_q428(w_sr) >>> 4;
    assign w_ci = sat_q428(w_si) >>> 4;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (start) n_state = F_MUL;
            F_MUL:  n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        busy   = (r_state != F_IDLE);
        w_take = (r_state == F_IDLE) && start;
        o_push = (r_state == F_PUSH) && !i_full;
    end

    assign o_job = '{col: r_col, row: r_row, cr: w_cr, ci: w_ci};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_col <= i_pix.pixel_col;
            r_row <= i_pix.pixel_row;
        end
        if (r_state == F_MUL) begin
            r_pr <= w_pr;
            r_pi <= w_pi;
        end
    end

endmodule

FILE: rtl/mep_fifo.sv
`timescale 1ns / 1ps
module mep_fifo import mep_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_push && o_full))
        else $error("transfer into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_pop && o_empty))
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count out of range");

endmodule

FILE: rtl/mep_back.sv
`timescale 1ns / 1ps
module mep_back import mep_pkg::*; #(
    parameter int MAX_ITER = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_job     i_job,
    output logic     o_pop,
    output logic     o_done,
    output t_pix_out o_pix
);

    localparam int NW = $clog2(MAX_ITER + 3);

    t_bst r_state, n_state;
    logic [9:0] r_col, r_row;
    logic signed [31:0] r_cr, r_ci, r_zr, r_zi;
    logic signed [63:0] r_rr, r_ii, r_ri;
    logic [NW-1:0] r_n;
    logic r_done;
    t_pix_out r_pix;

    logic signed [64:0] w_mag;
    logic signed [65:0] w_re, w_im;
    logic w_cont;
    logic [NW-1:0] w_count;
    logic signed [17:0] w_p;
    logic [31:0] w_colour;

    assign w_mag  = {r_rr[63], r_rr} + {r_ii[63], r_ii};
    assign w_cont = (r_n <= NW'(MAX_ITER)) && (w_mag <= ESCAPE_LIMIT);
    assign w_re   = {{2{r_rr[63]}}, r_rr} - {{2{r_ii[63]}}, r_ii}
                  + {{10{r_cr[31]}}, r_cr, 24'd0};
    assign w_im   = {r_ri[63], r_ri, 1'b0} + {{10{r_ci[31]}}, r_ci, 24'd0};

    assign w_count = r_n + NW'(1);
    assign w_p     = trunc_z(r_zi) * trunc_z(r_zr);
    assign w_colour = (w_count >= NW'(MAX_ITER)) ? COLOUR_INSIDE
                    : ({{(32-NW){1'b0}}, w_count} - {{14{w_p[17]}}, w_p});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_empty) n_state = B_SQ;
            B_SQ:   n_state = B_UPD;
            B_UPD:  n_state = w_cont ? B_SQ : B_FIN;
            B_FIN:  n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_state == B_IDLE) && !i_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == B_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (o_pop) begin
            r_n <= '0;
        end else if (r_state == B_UPD && w_cont) begin
            r_n <= r_n + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_col <= i_job.col;
                r_row <= i_job.row;
                r_cr  <= i_job.cr;
                r_ci  <= i_job.ci;
                r_zr  <= '0;
                r_zi  <= '0;
            end
            B_SQ: begin
                r_rr <= r_zr * r_zr;
                r_ii <= r_zi * r_zi;
                r_ri <= r_zr * r_zi;
            end
            B_UPD: begin
                if (w_cont) begin
                    r_zr <= w_re[55:24];
                    r_zi <= w_im[55:24];
                end
            end
            B_FIN: begin
                r_pix <= '{out_col: r_col, out_row: r_row, pixel_colour: w_colour};
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_pix  = r_pix;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_n <= NW'(MAX_ITER + 1))
        else $error("iteration count past limit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SQ) |=> (r_state == B_UPD))
        else $error("square step not followed by update");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FIN) |=> o_done)
        else $error("finished pixel without result");

endmodule

FILE: rtl/mandelbrot_escape_pixel_top.sv
`timescale 1ns / 1ps
// each escape iteration is a square state then an update state (B_SQ, B_UPD)
// the iteration loop (three 32x32 multiplies then update/escape test) sets the pace
// throughput: one pixel per back end loop; a 2-entry queue lets the front take the next start
// busy stays high through the multiply and push states after start, longer while the queue is full
// synchronous active-low reset; config registers return to their reset values
// results come as a one-cycle o_done strobe; the receiver cannot stall
module mandelbrot_escape_pixel_top import mep_pkg::*; #(
    parameter int MAX_ITER = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_pix_in             i_pix,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output logic                o_done,
    output t_pix_out            o_pix
);

    t_job w_push_job, w_pop_job;
    logic w_push, w_pop, w_full, w_empty;

    mep_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pix      (i_pix),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    mep_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    mep_back #(.MAX_ITER(MAX_ITER)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_pop_job),
        .o_pop   (w_pop),
        .o_done  (o_done),
        .o_pix   (o_pix)
    );

endmodule
